FILE: sv/q4q8_pkg.sv
// shared types, constants and single-precision arithmetic functions for the q4/q8 dot product
package q4q8_pkg;

  localparam int BLOCK_ELEMS = 32;
  localparam int LANES       = 8;
  localparam int STEPS       = BLOCK_ELEMS / LANES;
  localparam int STEP_W      = $clog2(STEPS);
  localparam int ACC_W       = 17;

  localparam logic [3:0]  NIB_BIAS    = 4'h8;
  localparam logic [17:0] HALF_EXP_ADJ = 18'h1C000;
  localparam logic [7:0]  EXP_BIAS    = 8'd127;
  localparam logic [7:0]  EXP_MAX     = 8'hFF;

  typedef struct packed {
    logic              load;
    logic              dot;
    logic [STEP_W-1:0] idx;
    logic              cvt;
    logic              mul_w;
    logic              mul_a;
    logic              add;
  } q4q8_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } q4q8_stat_t;

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [17:0] e;
    e = {3'b000, h[14:0]} + HALF_EXP_ADJ;
    if (h[14:0] == 15'd0) return {h[15], 31'd0};
    return {h[15], e[17:0], 13'd0};
  endfunction

  function automatic logic [31:0] int_to_float(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    logic [4:0]       pos;
    logic [39:0]      norm;
    logic [7:0]       e;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    pos = 5'd0;
    for (int i = 0; i < ACC_W; i++) begin
      if (mag[i]) pos = 5'(i);
    end
    norm = {mag, 23'd0} >> pos;
    e = EXP_BIAS + {3'b000, pos};
    if (mag == '0) return 32'd0;
    return {v[ACC_W-1], e, norm[22:0]};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [47:0] p;
    logic [9:0]  e;
    logic [23:0] m;
    logic        g;
    logic        st;
    logic [24:0] mr;
    s = a[31] ^ b[31];
    p = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    e = {2'b00, a[30:23]} + {2'b00, b[30:23]} - {2'b00, EXP_BIAS};
    if (p[47]) begin
      m  = p[47:24];
      g  = p[23];
      st = |p[22:0];
      e  = e + 10'd1;
    end else begin
      m  = p[46:23];
      g  = p[22];
      st = |p[21:0];
    end
    mr = {1'b0, m} + {24'd0, g & (st | m[0])};
    if (mr[24]) begin
      e  = e + 10'd1;
      mr = 25'd0;
    end
    if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
    return {s, e[7:0], mr[22:0]};
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [26:0] mx;
    logic [26:0] my;
    logic [26:0] mys;
    logic [53:0] sh;
    logic [7:0]  d;
    logic [9:0]  e;
    logic [27:0] s28;
    logic [26:0] df;
    logic [26:0] r;
    logic [4:0]  lz;
    logic        found;
    logic [24:0] mr;
    if (a[30:23] == EXP_MAX) return a;
    if (b[30:23] == EXP_MAX) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (b[30:0] == 31'd0) return a;
    if (a[30:0] == 31'd0) return b;
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    mx = {1'b1, x[22:0], 3'b000};
    my = {1'b1, y[22:0], 3'b000};
    d  = x[30:23] - y[30:23];
    sh = {my, 27'd0} >> d;
    if (d >= 8'd27) mys = 27'd1;
    else mys = sh[53:27] | {26'd0, |sh[26:0]};
    e = {2'b00, x[30:23]};
    r = '0;
    if (x[31] == y[31]) begin
      s28 = {1'b0, mx} + {1'b0, mys};
      if (s28[27]) begin
        r = {s28[27:2], s28[1] | s28[0]};
        e = e + 10'd1;
      end else begin
        r = s28[26:0];
      end
    end else begin
      df = mx - mys;
      if (df == 27'd0) return 32'd0;
      lz = 5'd0;
      found = 1'b0;
      for (int i = 0; i < 27; i++) begin
        if (!found && df[26-i]) begin
          lz = 5'(i);
          found = 1'b1;
        end
      end
      r = df << lz;
      e = e - {5'd0, lz};
    end
    mr = {1'b0, r[26:3]} + {24'd0, r[2] & ((|r[1:0]) | r[3])};
    if (mr[24]) begin
      e  = e + 10'd1;
      mr = 25'd0;
    end
    if (e >= {2'b00, EXP_MAX}) return {x[31], EXP_MAX, 23'd0};
    return {x[31], e[7:0], mr[22:0]};
  endfunction

endpackage

FILE: sv/q4_q8_block_dot_product.sv
// top level of the q4/q8 block dot product accumulator
//
// input channel: one beat carries a weight block (16 packed nibble bytes plus an
// fp16 scale) and an activation block (32 signed bytes plus an fp16 scale), with
// last_block marking the final pair of a dot product. in_stall is high while a
// beat is being worked on.
// each beat is captured, then worked through four integer steps of eight lane
// products each, then convert, two float multiplies and the float add; the
// shared integer lanes and the float chain are used in turn, so a new beat is
// taken only after the float add of the one before it.
// output channel: on a beat with last_block the accumulated single-precision
// sum appears on dot_result with out_valid in the cycle after the final float
// add, and the running sum returns to +0.
// beats without last_block produce no output.
// if the receiver stalls, the result is held in the output register and the
// next beat is still accepted; its float add waits only if that beat carries
// last_block while a held result is still stalled.
// reset clears the running sum to +0 and drops out_valid.
module q4_q8_block_dot_product (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] weight_bytes_low,
  input  logic [63:0] weight_bytes_high,
  input  logic [15:0] weight_scale,
  input  logic [63:0] act_bytes_0,
  input  logic [63:0] act_bytes_1,
  input  logic [63:0] act_bytes_2,
  input  logic [63:0] act_bytes_3,
  input  logic [15:0] act_scale,
  input  logic        last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] dot_result
);
  import q4q8_pkg::*;

  q4q8_cmd_t  cmd;
  q4q8_stat_t stat;

  q4q8_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  q4q8_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .weight_bytes_low  (weight_bytes_low),
    .weight_bytes_high (weight_bytes_high),
    .weight_scale      (weight_scale),
    .act_bytes_0       (act_bytes_0),
    .act_bytes_1       (act_bytes_1),
    .act_bytes_2       (act_bytes_2),
    .act_bytes_3       (act_bytes_3),
    .act_scale         (act_scale),
    .last_block        (last_block),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .dot_result        (dot_result)
  );

endmodule

FILE: sv/q4q8_ctrl.sv
// controller state machine sequencing load, integer dot steps and float operations
module q4q8_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  q4q8_pkg::q4q8_stat_t stat,
  output q4q8_pkg::q4q8_cmd_t  cmd
);
  import q4q8_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DOT  = 6'b000010,
    S_CVT  = 6'b000100,
    S_MULW = 6'b001000,
    S_MULA = 6'b010000,
    S_ADD  = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              add_go;

  assign in_stall = (state != S_IDLE);
  assign add_go   = !stat.last || !stat.out_busy;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.idx    = step;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DOT;
          step_next  = '0;
        end
      end
      S_DOT: begin
        cmd.dot   = 1'b1;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(STEPS - 1)) state_next = S_CVT;
      end
      S_CVT: begin
        cmd.cvt    = 1'b1;
        state_next = S_MULW;
      end
      S_MULW: begin
        cmd.mul_w  = 1'b1;
        state_next = S_MULA;
      end
      S_MULA: begin
        cmd.mul_a  = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        if (add_go) begin
          cmd.add    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

FILE: sv/q4q8_dpath.sv
// datapath: operand registers, lane multipliers, float convert, multiply, add and output register
module q4q8_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  q4q8_pkg::q4q8_cmd_t  cmd,
  output q4q8_pkg::q4q8_stat_t stat,
  input  logic [63:0]          weight_bytes_low,
  input  logic [63:0]          weight_bytes_high,
  input  logic [15:0]          weight_scale,
  input  logic [63:0]          act_bytes_0,
  input  logic [63:0]          act_bytes_1,
  input  logic [63:0]          act_bytes_2,
  input  logic [63:0]          act_bytes_3,
  input  logic [15:0]          act_scale,
  input  logic                 last_block,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          dot_result
);
  import q4q8_pkg::*;

  logic [63:0]              wl;
  logic [63:0]              wh;
  logic [63:0]              act [STEPS];
  logic [15:0]              ws;
  logic [15:0]              as;
  logic                     last;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  lane_sum;
  logic [31:0]              prod;
  logic [31:0]              sum;
  logic [31:0]              sum_next;
  logic [63:0]              wsel;
  logic [63:0]              asel;

  assign stat.last     = last;
  assign stat.out_busy = out_valid & out_stall;

  assign wsel     = cmd.idx[0] ? wh : wl;
  assign asel     = act[cmd.idx];
  assign sum_next = fadd(sum, prod);

  always_comb begin
    logic [3:0]         nib;
    logic signed [4:0]  wv;
    logic signed [7:0]  av;
    logic signed [12:0] pv;
    lane_sum = '0;
    for (int k = 0; k < LANES; k++) begin
      nib = cmd.idx[1] ? wsel[8*k+4 +: 4] : wsel[8*k +: 4];
      wv  = signed'({1'b0, nib} - {1'b0, NIB_BIAS});
      av  = signed'(asel[8*k +: 8]);
      pv  = wv * av;
      lane_sum = lane_sum + ACC_W'(pv);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wl     <= weight_bytes_low;
      wh     <= weight_bytes_high;
      act[0] <= act_bytes_0;
      act[1] <= act_bytes_1;
      act[2] <= act_bytes_2;
      act[3] <= act_bytes_3;
      ws     <= weight_scale;
      as     <= act_scale;
      last   <= last_block;
      acc    <= '0;
    end else if (cmd.dot) begin
      acc <= acc + lane_sum;
    end
    if (cmd.cvt) prod <= int_to_float(acc);
    else if (cmd.mul_w) prod <= fmul(prod, widen_half(ws));
    else if (cmd.mul_a) prod <= fmul(prod, widen_half(as));
    if (cmd.add && last) dot_result <= sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.add) sum <= last ? 32'd0 : sum_next;
      if (cmd.add && last) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule
